>>> rtl/point_to_polyline_nearest_top_macros.svh
// Assertion macros for the nearest-point-on-polyline block.
`ifndef POINT_TO_POLYLINE_NEAREST_TOP_MACROS_SVH
`define POINT_TO_POLYLINE_NEAREST_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PPN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PPN_ASSERT(lbl, prop, msg)
`define PPN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/ppn_pkg.sv
// Shared types, constants and helpers of the nearest-point-on-polyline block.
`timescale 1ns / 1ps
package ppn_pkg;
    localparam int COORD_W     = 32;
    localparam int MUL_W       = COORD_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COORD_W:0]   t_diff;

    // One segment job, or a bare end-of-run marker when eval is low.
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord qx;
        t_coord qy;
        logic   eval;
        logic   fin;
    } t_job;

    function automatic logic [MUL_W-1:0] mag(input t_diff v);
        logic [MUL_W-1:0] r;
        r = v[COORD_W] ? $unsigned(-v) : $unsigned(v);
        return r;
    endfunction
endpackage

>>> rtl/point_to_polyline_nearest_top.sv
// Top level of the nearest-point-on-polyline block.
//
//  channel   direction  handshake                 payload
//  s         in         i_s_tvalid / o_s_tready   tdata, tuser, tlast (one vertex)
//  m         out        o_m_tvalid / i_m_tready   tdata, tuser (one result per path)
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_data (closed path)
//
// Each segment passes through the shared 33x33 multiplier and the decision step;
// when the projection falls inside rather than clamping to an end, a bit-serial
// quotient also runs for each axis. A vertex gives up to two segments.
// The end of a path adds a bit-serial square root before the result.
// Reset is synchronous and active low; it clears all control and running state.
// A four-entry job queue lets the vertex input run ahead while the engine or the
// result register is stalled.
`timescale 1ns / 1ps
module point_to_polyline_nearest_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,    // closed_path
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,     // query_x, query_y, vertex_x, vertex_y
    input  logic [1:0]   i_s_tuser,     // starts_polygon, ends_polygon
    input  logic         i_s_tlast,     // ends_path
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,     // nearest_x, nearest_y, distance
    output logic         o_m_tuser      // found
);
    logic          w_full, w_empty, w_push, w_pop;
    ppn_pkg::t_job w_job_in, w_job_out;

    assign o_cfg_ready = 1'b1;

    ppn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    ppn_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_empty(w_empty),
        .o_job  (w_job_out)
    );

    ppn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );
endmodule

>>> rtl/ppn_front.sv
// Front end: tracks polygon state and turns each vertex into segment jobs.
`timescale 1ns / 1ps
module ppn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_data,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [127:0]  i_s_tdata,
    input  logic [1:0]    i_s_tuser,
    input  logic          i_s_tlast,
    input  logic          i_full,
    output logic          o_push,
    output ppn_pkg::t_job o_job
);
    logic            r_closed;
    logic            r_in_poly;
    logic            r_ph;
    ppn_pkg::t_coord r_fx, r_fy, r_px, r_py;

    ppn_pkg::t_coord w_qx, w_qy, w_vx, w_vy, w_fx, w_fy;
    logic            w_new, w_seg1, w_seg2, w_endp, w_two, w_accept;
    ppn_pkg::t_job   w_j1, w_j2, w_jf;

    assign w_qx   = i_s_tdata[31:0];
    assign w_qy   = i_s_tdata[63:32];
    assign w_vx   = i_s_tdata[95:64];
    assign w_vy   = i_s_tdata[127:96];
    assign w_new  = i_s_tuser[0] || !r_in_poly;
    assign w_endp = i_s_tuser[1] || i_s_tlast;
    assign w_seg1 = !w_new;
    assign w_seg2 = w_endp && r_closed;
    assign w_two  = w_seg1 && w_seg2;
    assign w_fx   = w_new ? w_vx : r_fx;
    assign w_fy   = w_new ? w_vy : r_fy;

    always_comb begin
        w_j1 = '{ax: r_px, ay: r_py, bx: w_vx, by: w_vy, qx: w_qx, qy: w_qy,
                 eval: 1'b1, fin: i_s_tlast && !w_seg2};
        w_j2 = '{ax: w_vx, ay: w_vy, bx: w_fx, by: w_fy, qx: w_qx, qy: w_qy,
                 eval: 1'b1, fin: i_s_tlast};
        w_jf = '{ax: w_vx, ay: w_vy, bx: w_vx, by: w_vy, qx: w_qx, qy: w_qy,
                 eval: 1'b0, fin: 1'b1};
    end

    // A vertex that needs two segments is held until its second segment is pushed.
    assign o_s_tready = !i_full && (r_ph || !w_two);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_push     = i_s_tvalid && !i_full && (r_ph || w_seg1 || w_seg2 || i_s_tlast);
    assign o_job      = r_ph ? w_j2 : (w_seg1 ? w_j1 : (w_seg2 ? w_j2 : w_jf));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed  <= 1'b0;
            r_in_poly <= 1'b0;
            r_ph      <= 1'b0;
            r_fx      <= '0;
            r_fy      <= '0;
            r_px      <= '0;
            r_py      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_closed <= i_cfg_data;
            end
            if (w_accept) begin
                r_ph      <= 1'b0;
                r_in_poly <= !w_endp;
                r_fx      <= w_fx;
                r_fy      <= w_fy;
                r_px      <= w_vx;
                r_py      <= w_vy;
            end else if (o_push) begin
                r_ph <= 1'b1;
            end
        end
    end
endmodule

>>> rtl/ppn_queue.sv
// Short job queue between the front end and the segment engine.
`timescale 1ns / 1ps
`include "point_to_polyline_nearest_top_macros.svh"
module ppn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppn_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output ppn_pkg::t_job o_job
);
    ppn_pkg::t_job                 r_mem [ppn_pkg::QUEUE_DEPTH];
    logic [ppn_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [ppn_pkg::QPTR_W:0]      r_cnt;
    logic                          w_push, w_pop;

    assign o_full  = (r_cnt == (ppn_pkg::QPTR_W+1)'(ppn_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    `PPN_ASSERT(a_no_push_full, o_full |-> !i_push, "job pushed into a full queue")
    `PPN_ASSERT(a_cnt_up, (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1), "count lost")
endmodule

>>> rtl/ppn_back.sv
// Segment engine: projection, squared distance, best tracking and final root.
`timescale 1ns / 1ps
`include "point_to_polyline_nearest_top_macros.svh"
module ppn_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  ppn_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [95:0]   o_m_tdata,
    output logic          o_m_tuser
);
    localparam int MW = ppn_pkg::MUL_W;
    localparam int CW = ppn_pkg::COORD_W;

    localparam logic [4:0] B_IDLE = 5'd0,  B_DIFF = 5'd1,  B_P1 = 5'd2,  B_P2 = 5'd3;
    localparam logic [4:0] B_P3   = 5'd4,  B_P4   = 5'd5,  B_LEN = 5'd6, B_DEC = 5'd7;
    localparam logic [4:0] B_NL   = 5'd8,  B_NH   = 5'd9,  B_NS = 5'd10, B_DIV = 5'd11;
    localparam logic [4:0] B_RND  = 5'd12, B_E1   = 5'd13, B_E2 = 5'd14, B_E3 = 5'd15;
    localparam logic [4:0] B_FIN  = 5'd16, B_SQ   = 5'd17, B_OUT = 5'd18;

    logic [4:0]            r_state;
    ppn_pkg::t_job         r_job;
    ppn_pkg::t_diff        r_dx, r_dy, r_wx, r_wy;
    logic [2*MW-1:0]       r_prod;
    logic signed [2*MW:0]  r_dot;
    logic [2*MW:0]         r_len;
    logic                  r_axis;
    logic [63:0]           r_nlo;
    logic [2*MW-1:0]       r_rem;
    logic [31:0]           r_qsh, r_q;
    logic [4:0]            r_cnt;
    ppn_pkg::t_coord       r_px, r_py;
    logic [63:0]           r_sqx;
    logic                  r_have;
    logic [63:0]           r_best;
    ppn_pkg::t_coord       r_bx, r_by;
    logic [63:0]           r_op, r_res;
    logic                  r_ov;
    logic [95:0]           r_od;
    logic                  r_of;

    logic [MW-1:0]         w_ma, w_mb, w_m;
    logic [2*MW:0]         w_term;
    logic                  w_neg;
    logic [97:0]           w_num;
    logic [2*MW:0]         w_rem2, w_twice;
    logic                  w_ge;
    logic [32:0]           w_qr;
    logic signed [CW+1:0]  w_pnew;
    ppn_pkg::t_coord       w_a;
    logic                  w_dneg;
    ppn_pkg::t_diff        w_ex, w_ey;
    logic [64:0]           w_sq;
    logic [63:0]           w_sqs;
    logic [6:0]            w_sh;
    logic [63:0]           w_one, w_t, w_fin;
    logic [31:0]           w_dist;
    logic                  w_load;

    assign w_m    = r_axis ? ppn_pkg::mag(r_dy) : ppn_pkg::mag(r_dx);
    assign w_ex   = {r_px[CW-1], r_px} - {r_job.qx[CW-1], r_job.qx};
    assign w_ey   = {r_py[CW-1], r_py} - {r_job.qy[CW-1], r_job.qy};

    always_comb begin
        case (r_state)
            B_P1:    begin w_ma = ppn_pkg::mag(r_dx); w_mb = ppn_pkg::mag(r_wx); end
            B_P2:    begin w_ma = ppn_pkg::mag(r_dy); w_mb = ppn_pkg::mag(r_wy); end
            B_P3:    begin w_ma = ppn_pkg::mag(r_dx); w_mb = ppn_pkg::mag(r_dx); end
            B_P4:    begin w_ma = ppn_pkg::mag(r_dy); w_mb = ppn_pkg::mag(r_dy); end
            B_NL:    begin w_ma = {1'b0, r_dot[31:0]}; w_mb = w_m; end
            B_NH:    begin w_ma = r_dot[64:32]; w_mb = w_m; end
            B_E1:    begin w_ma = ppn_pkg::mag(w_ex); w_mb = ppn_pkg::mag(w_ex); end
            B_E2:    begin w_ma = ppn_pkg::mag(w_ey); w_mb = ppn_pkg::mag(w_ey); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // Signed accumulation of the dot product from magnitude products.
    assign w_neg  = (r_state == B_P2) ? (r_dx[CW] ^ r_wx[CW]) : (r_dy[CW] ^ r_wy[CW]);
    assign w_term = w_neg ? -{1'b0, r_prod} : {1'b0, r_prod};

    assign w_num   = {r_prod, 32'b0} + {34'b0, r_nlo};
    assign w_rem2  = {r_rem, r_qsh[31]};
    assign w_ge    = (w_rem2 >= r_len);
    assign w_twice = {r_rem, 1'b0};
    assign w_qr    = {1'b0, r_q} + {32'b0, (w_twice >= r_len)};
    assign w_a     = r_axis ? r_job.ay : r_job.ax;
    assign w_dneg  = r_axis ? r_dy[CW] : r_dx[CW];
    assign w_pnew  = w_dneg ? ({{2{w_a[CW-1]}}, w_a} - {1'b0, w_qr})
                            : ({{2{w_a[CW-1]}}, w_a} + {1'b0, w_qr});

    assign w_sq  = {1'b0, r_sqx} + {1'b0, r_prod[63:0]};
    assign w_sqs = w_sq[64] ? {64{1'b1}} : w_sq[63:0];

    assign w_sh   = 7'd62 - {1'b0, r_cnt, 1'b0};
    assign w_one  = 64'd1 << w_sh;
    assign w_t    = r_res + w_one;
    assign w_fin  = r_res + {63'b0, (r_op > r_res)};
    assign w_dist = (w_fin > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w_fin[31:0];

    assign o_pop  = (r_state == B_IDLE) && !i_empty;
    assign w_load = (r_state == B_OUT) && (!r_ov || i_m_tready);

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            B_IDLE:  if (!i_empty) r_job <= i_job;
            B_DIFF: begin
                r_dx <= {r_job.bx[CW-1], r_job.bx} - {r_job.ax[CW-1], r_job.ax};
                r_dy <= {r_job.by[CW-1], r_job.by} - {r_job.ay[CW-1], r_job.ay};
                r_wx <= {r_job.qx[CW-1], r_job.qx} - {r_job.ax[CW-1], r_job.ax};
                r_wy <= {r_job.qy[CW-1], r_job.qy} - {r_job.ay[CW-1], r_job.ay};
            end
            B_P2:    r_dot <= $signed(w_term);
            B_P3:    r_dot <= r_dot + $signed(w_term);
            B_P4:    r_len <= {1'b0, r_prod};
            B_LEN:   r_len <= r_len + {1'b0, r_prod};
            B_DEC: begin
                r_axis <= 1'b0;
                if (r_dot <= 0) begin
                    r_px <= r_job.ax;
                    r_py <= r_job.ay;
                end else if ($unsigned(r_dot) >= r_len) begin
                    r_px <= r_job.bx;
                    r_py <= r_job.by;
                end
            end
            B_NH:    r_nlo <= r_prod[63:0];
            B_NS: begin
                r_rem <= w_num[97:32];
                r_qsh <= w_num[31:0];
                r_q   <= '0;
            end
            B_DIV: begin
                r_rem <= w_ge ? (2*MW)'(w_rem2 - r_len) : w_rem2[2*MW-1:0];
                r_qsh <= {r_qsh[30:0], 1'b0};
                r_q   <= {r_q[30:0], w_ge};
            end
            B_RND: begin
                if (r_axis) r_py <= w_pnew[CW-1:0];
                else        r_px <= w_pnew[CW-1:0];
                r_axis <= 1'b1;
            end
            B_E2:    r_sqx <= r_prod[63:0];
            B_FIN: begin
                r_op  <= r_best;
                r_res <= '0;
            end
            B_SQ: begin
                if (r_op >= w_t) begin
                    r_op  <= r_op - w_t;
                    r_res <= (r_res >> 1) + w_one;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_od <= r_have ? {w_dist, r_by, r_bx} : '0;
            r_of <= r_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_have  <= 1'b0;
            r_best  <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load)               r_ov <= 1'b1;
            else if (i_m_tready)      r_ov <= 1'b0;
            case (r_state)
                B_IDLE:  if (!i_empty) r_state <= i_job.eval ? B_DIFF : B_FIN;
                B_DIFF:  r_state <= B_P1;
                B_P1:    r_state <= B_P2;
                B_P2:    r_state <= B_P3;
                B_P3:    r_state <= B_P4;
                B_P4:    r_state <= B_LEN;
                B_LEN:   r_state <= B_DEC;
                B_DEC: begin
                    if (r_dot <= 0 || $unsigned(r_dot) >= r_len) r_state <= B_E1;
                    else                                          r_state <= B_NL;
                end
                B_NL:    r_state <= B_NH;
                B_NH:    r_state <= B_NS;
                B_NS: begin
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) r_state <= B_RND;
                end
                B_RND:   r_state <= r_axis ? B_E1 : B_NL;
                B_E1:    r_state <= B_E2;
                B_E2:    r_state <= B_E3;
                B_E3: begin
                    if (!r_have || w_sqs < r_best) begin
                        r_have <= 1'b1;
                        r_best <= w_sqs;
                        r_bx   <= r_px;
                        r_by   <= r_py;
                    end
                    r_state <= r_job.fin ? B_FIN : B_IDLE;
                end
                B_FIN: begin
                    r_cnt   <= '0;
                    r_state <= r_have ? B_SQ : B_OUT;
                end
                B_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_load) begin
                        r_have  <= 1'b0;
                        r_best  <= '0;
                        r_bx    <= '0;
                        r_by    <= '0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_of;

    `PPN_ASSERT(a_out_clears, w_load |=> (r_ov && !r_have), "result load did not clear best")
    `PPN_ASSERT(a_pop_idle, o_pop |=> (r_state != B_IDLE), "job popped but engine stayed idle")
endmodule
